>>> rtl/core/phgb_pkg.sv
// Shared types and constants for the pixel hue, grey and black-white recolor block.
package phgb_pkg;

    // Channel width of one RGB888 pixel.
    localparam int unsigned PIX_W = 8;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_VAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREY_EN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BW_EN    = 2'd3;
    localparam int unsigned CFG_DATA_W = 9;

    // Hue angle handling.
    localparam int unsigned HUE_W = 9;
    localparam logic [HUE_W-1:0] HUE_FULL_TURN = 9'd360;
    localparam int unsigned K_W = 6;

    // Division by 60 as a multiply by ceil(2^20 / 60) and a shift by 20.
    // Exact for every dividend below 2^20 / 44, which covers 255 * 60.
    localparam int unsigned RECIP60_SHIFT = 20;
    localparam int unsigned RECIP60_W = 15;
    localparam logic [RECIP60_W-1:0] RECIP60 = 15'd17477;
    localparam int unsigned SCALE_W = 21;
    localparam int unsigned HUE_PROD_W = PIX_W + SCALE_W;

    // Division by 3 as a multiply by ceil(2^11 / 3) and a shift by 11.
    // Exact for every sum of three channels.
    localparam int unsigned SUM_W = 10;
    localparam int unsigned RECIP3_SHIFT = 11;
    localparam logic [SUM_W-1:0] RECIP3 = 10'd683;
    localparam int unsigned AVG_PROD_W = 2 * SUM_W;

    // The 60-degree sector of the target hue, named by the colors it spans.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    // Settings as the datapath sees them; the hue is kept pre-decoded.
    typedef struct packed {
        logic               hue_en;
        sector_t            sector;
        logic [SCALE_W-1:0] scale;
        logic               grey_en;
        logic               bw_en;
    } cfg_t;

endpackage

>>> rtl/core/phgb_in_if.sv
// Input pixel channel: valid/ready handshake with an RGB888 payload.
interface phgb_in_if import phgb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

>>> rtl/core/phgb_out_if.sv
// Output pixel channel: valid/ready handshake with an RGB888 payload.
interface phgb_out_if import phgb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

>>> rtl/core/phgb_cfg.sv
// Configuration registers, with the target hue decoded into sector and scale on write.
module phgb_cfg import phgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic               hue_en_reg;
    sector_t            sector_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               grey_en_reg;
    logic               bw_en_reg;

    logic [HUE_W-1:0]   hue_wrap;
    logic [HUE_W-1:0]   sector_base;
    logic [HUE_W-1:0]   hue_off;
    logic [K_W-1:0]     k_val;
    sector_t            sector_next;
    logic [SCALE_W-1:0] scale_next;

    // Fold the angle into one turn, find its sector and the offset inside it.
    // The middle channel weight k rises through even sectors and falls through odd ones.
    always_comb
    begin
        hue_wrap = (cfg_wdata[HUE_W-1:0] >= HUE_FULL_TURN)
                 ? cfg_wdata[HUE_W-1:0] - HUE_FULL_TURN : cfg_wdata[HUE_W-1:0];
        if (hue_wrap >= 9'd300)
        begin
            sector_next = SEC_MAG_RED;
            sector_base = 9'd300;
        end
        else if (hue_wrap >= 9'd240)
        begin
            sector_next = SEC_BLU_MAG;
            sector_base = 9'd240;
        end
        else if (hue_wrap >= 9'd180)
        begin
            sector_next = SEC_CYN_BLU;
            sector_base = 9'd180;
        end
        else if (hue_wrap >= 9'd120)
        begin
            sector_next = SEC_GRN_CYN;
            sector_base = 9'd120;
        end
        else if (hue_wrap >= 9'd60)
        begin
            sector_next = SEC_YEL_GRN;
            sector_base = 9'd60;
        end
        else
        begin
            sector_next = SEC_RED_YEL;
            sector_base = 9'd0;
        end
        hue_off = hue_wrap - sector_base;
        k_val = sector_next[0] ? 6'd60 - hue_off[K_W-1:0] : hue_off[K_W-1:0];
        scale_next = {{(SCALE_W-K_W){1'b0}}, k_val}
                   * {{(SCALE_W-RECIP60_W){1'b0}}, RECIP60};
    end

    // Register writes; unknown indexes do not occur with a two-bit index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_en_reg  <= 1'b0;
            sector_reg  <= SEC_RED_YEL;
            scale_reg   <= '0;
            grey_en_reg <= 1'b0;
            bw_en_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HUE_EN:  hue_en_reg <= cfg_wdata[0];
                REG_HUE_VAL:
                begin
                    sector_reg <= sector_next;
                    scale_reg  <= scale_next;
                end
                REG_GREY_EN: grey_en_reg <= cfg_wdata[0];
                REG_BW_EN:   bw_en_reg <= cfg_wdata[0];
                default:     hue_en_reg <= hue_en_reg;
            endcase
        end
    end

    assign cfg.hue_en  = hue_en_reg;
    assign cfg.sector  = sector_reg;
    assign cfg.scale   = scale_reg;
    assign cfg.grey_en = grey_en_reg;
    assign cfg.bw_en   = bw_en_reg;

endmodule

>>> rtl/core/phgb_hue.sv
// Input pixel register and hue replacement stage with its result register.
module phgb_hue import phgb_pkg::*;
(
    input  logic   clk,
    input  logic   in_load,
    input  pixel_t pix_in,
    input  logic   hue_load,
    input  cfg_t   cfg,
    output pixel_t pix_hue
);

    pixel_t                  pix_in_reg;
    pixel_t                  hue_reg;
    pixel_t                  hue_next;
    logic [PIX_W-1:0]        hi;
    logic [PIX_W-1:0]        lo;
    logic [PIX_W-1:0]        delta;
    logic [HUE_PROD_W-1:0]   prod;
    logic [PIX_W-1:0]        mid;

    // Capture the accepted pixel.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            pix_in_reg <= pix_in;
        end
    end

    // Keep max and min, rebuild the middle channel from the configured hue.
    always_comb
    begin
        hi = (pix_in_reg.red > pix_in_reg.green) ? pix_in_reg.red : pix_in_reg.green;
        hi = (hi > pix_in_reg.blue) ? hi : pix_in_reg.blue;
        lo = (pix_in_reg.red < pix_in_reg.green) ? pix_in_reg.red : pix_in_reg.green;
        lo = (lo < pix_in_reg.blue) ? lo : pix_in_reg.blue;
        delta = hi - lo;
        prod = {{SCALE_W{1'b0}}, delta} * {{PIX_W{1'b0}}, cfg.scale};
        mid = lo + prod[RECIP60_SHIFT+PIX_W-1:RECIP60_SHIFT];

        hue_next = pix_in_reg;
        if (cfg.hue_en)
        begin
            case (cfg.sector)
                SEC_RED_YEL: hue_next = '{red: hi,  green: mid, blue: lo};
                SEC_YEL_GRN: hue_next = '{red: mid, green: hi,  blue: lo};
                SEC_GRN_CYN: hue_next = '{red: lo,  green: hi,  blue: mid};
                SEC_CYN_BLU: hue_next = '{red: lo,  green: mid, blue: hi};
                SEC_BLU_MAG: hue_next = '{red: mid, green: lo,  blue: hi};
                default:     hue_next = '{red: hi,  green: lo,  blue: mid};
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (hue_load)
        begin
            hue_reg <= hue_next;
        end
    end

    assign pix_hue = hue_reg;

endmodule

>>> rtl/core/phgb_tone.sv
// Greyscale and black-white stage with the output pixel register.
module phgb_tone import phgb_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  pixel_t pix_in,
    input  cfg_t   cfg,
    output pixel_t pix_out
);

    pixel_t                  out_reg;
    pixel_t                  out_next;
    logic [SUM_W-1:0]        sum;
    logic [AVG_PROD_W-1:0]   avg_prod;
    logic [PIX_W-1:0]        avg;
    logic [PIX_W-1:0]        bw;

    // Channel average by reciprocal multiply; black-white thresholds it at 128.
    // With grey on the average of the grey pixel is the same value.
    always_comb
    begin
        sum = {2'b00, pix_in.red} + {2'b00, pix_in.green} + {2'b00, pix_in.blue};
        avg_prod = {{SUM_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP3};
        avg = avg_prod[RECIP3_SHIFT+PIX_W-1:RECIP3_SHIFT];
        bw = avg[PIX_W-1] ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
        if (cfg.bw_en)
        begin
            out_next = '{red: bw, green: bw, blue: bw};
        end
        else if (cfg.grey_en)
        begin
            out_next = '{red: avg, green: avg, blue: avg};
        end
        else
        begin
            out_next = pix_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign pix_out = out_reg;

    // A black-white pixel is pure black or pure white on all channels.
    a_bw_pure: assert property (@(posedge clk)
        load && cfg.bw_en |=> (out_reg.red == out_reg.green)
                            && (out_reg.green == out_reg.blue)
                            && ((out_reg.red == 8'd0) || (out_reg.red == 8'd255)))
        else $error("black-white output is not a pure level");

    // A grey pixel has three equal channels.
    a_grey_flat: assert property (@(posedge clk)
        load && cfg.grey_en |=> (out_reg.red == out_reg.green)
                              && (out_reg.green == out_reg.blue))
        else $error("greyscale output channels differ");

endmodule

>>> rtl/core/pixel_hue_set_grey_bw_recolor.sv
// An accepted input transaction passes the input, hue and output registers in turn.
// Throughput: one pixel per cycle while the output is ready; the three register stages
// (input, hue, output) each advance whenever the next stage is empty or handing on its pixel.
// Reset clears all stage valid flags and sets every configuration register to 0,
// so the block comes out of reset passing pixels through unchanged.
module pixel_hue_set_grey_bw_recolor import phgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    phgb_in_if.sink               pix_in,
    phgb_out_if.source            pix_out
);

    cfg_t   cfg;
    pixel_t in_pix;
    pixel_t hue_pix;
    pixel_t out_pix;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic load1;
    logic load2;
    logic load3;

    // Each stage takes a new pixel when it is empty or its pixel moves on.
    assign s3_ready = !s3_valid_reg || pix_out.ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign load1    = pix_in.valid && s1_ready;
    assign load2    = s1_valid_reg && s2_ready;
    assign load3    = s2_valid_reg && s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pix_in.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign in_pix = '{red: pix_in.red_in, green: pix_in.green_in, blue: pix_in.blue_in};

    phgb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    phgb_hue u_hue
    (
        .clk      (clk),
        .in_load  (load1),
        .pix_in   (in_pix),
        .hue_load (load2),
        .cfg      (cfg),
        .pix_hue  (hue_pix)
    );

    phgb_tone u_tone
    (
        .clk     (clk),
        .load    (load3),
        .pix_in  (hue_pix),
        .cfg     (cfg),
        .pix_out (out_pix)
    );

    assign pix_in.ready      = s1_ready;
    assign pix_out.valid     = s3_valid_reg;
    assign pix_out.red_out   = out_pix.red;
    assign pix_out.green_out = out_pix.green;
    assign pix_out.blue_out  = out_pix.blue;

    // An accepted transaction always occupies the input stage next cycle.
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pix_in.valid && pix_in.ready |=> s1_valid_reg)
        else $error("accepted pixel lost at the input stage");

    // With the whole pipeline full and the output stalled, no input is taken.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && s3_valid_reg && !pix_out.ready |-> !pix_in.ready)
        else $error("input accepted while the pipeline is full and stalled");

    // A stage that holds a pixel and cannot pass it on keeps it.
    a_hue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg)
        else $error("hue stage dropped a stalled pixel");

endmodule

>>> sim/pixel_hue_set_grey_bw_recolor_tb.sv
// Self-checking testbench for the pixel hue, grey and black-white recolor block.
`timescale 1ns / 1ps

module pixel_hue_set_grey_bw_recolor_tb import phgb_pkg::*;;

    localparam int unsigned  LONG_HOLD    = 300;
    localparam int unsigned  DRAIN_CYCLES = 6;
    localparam int unsigned  RAND_PHASES  = 11;
    localparam int unsigned  PHASE_ITEMS  = 150;
    localparam longint unsigned TIMEOUT_NS = 5_000_000;

    // Predicts every output pixel and holds the ones still awaited.
    class recolor_scoreboard;
        pixel_t           expected_pixels[$];
        bit               hue_en;
        logic [HUE_W-1:0] hue_deg = '0;
        bit               grey_en;
        bit               bw_en;
        int unsigned      mismatches;
        int unsigned      checked;

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HUE_EN:  hue_en  = data[0];
                REG_HUE_VAL: hue_deg = data[HUE_W-1:0];
                REG_GREY_EN: grey_en = data[0];
                REG_BW_EN:   bw_en   = data[0];
                default: ;
            endcase
        endfunction

        // Hue replacement, then greyscale, then black-white, as configured.
        function pixel_t recolor(input pixel_t px);
            int unsigned r, g, b, hi, lo, delta, h, t, off60, mid, avg;
            sector_t     sec;
            pixel_t      res;
            r = 32'(px.red);
            g = 32'(px.green);
            b = 32'(px.blue);
            if (hue_en)
            begin
                hi = (r > g) ? r : g;
                hi = (hi > b) ? hi : b;
                lo = (r < g) ? r : g;
                lo = (lo < b) ? lo : b;
                delta = hi - lo;
                h = 32'(hue_deg);
                // Angles past a full turn wrap round the color circle.
                if (h >= 32'(HUE_FULL_TURN))
                    h = h - 32'(HUE_FULL_TURN);
                t = h % 120;
                off60 = (t >= 60) ? t - 60 : 60 - t;
                mid = lo + (delta * (60 - off60)) / 60;
                sec = sector_t'(h / 60);
                case (sec)
                    SEC_RED_YEL: begin r = hi;  g = mid; b = lo;  end
                    SEC_YEL_GRN: begin r = mid; g = hi;  b = lo;  end
                    SEC_GRN_CYN: begin r = lo;  g = hi;  b = mid; end
                    SEC_CYN_BLU: begin r = lo;  g = mid; b = hi;  end
                    SEC_BLU_MAG: begin r = mid; g = lo;  b = hi;  end
                    default:     begin r = hi;  g = lo;  b = mid; end
                endcase
            end
            if (grey_en)
            begin
                avg = (r + g + b) / 3;
                r = avg;
                g = avg;
                b = avg;
            end
            if (bw_en)
            begin
                avg = (r + g + b) / 3;
                avg = (avg < 128) ? 0 : 255;
                r = avg;
                g = avg;
                b = avg;
            end
            res.red   = r[PIX_W-1:0];
            res.green = g[PIX_W-1:0];
            res.blue  = b[PIX_W-1:0];
            return res;
        endfunction

        function void note_input(input pixel_t px);
            expected_pixels = {expected_pixels, recolor(px)};
        endfunction

        function void report(input string msg);
            if (mismatches < 10)
                $display("%s", msg);
            mismatches++;
        endfunction

        function void check_output(input pixel_t px);
            pixel_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("unexpected output %02h %02h %02h",
                                 px.red, px.green, px.blue));
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (px.red !== exp_px.red || px.green !== exp_px.green
                    || px.blue !== exp_px.blue)
                report($sformatf("output %0d: expected %02h %02h %02h, got %02h %02h %02h",
                                 checked, exp_px.red, exp_px.green, exp_px.blue,
                                 px.red, px.green, px.blue));
            checked++;
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    phgb_in_if  pix_in_ch ();
    phgb_out_if pix_out_ch ();

    recolor_scoreboard sb = new;
    int unsigned       in_count = 0;
    bit                tx_steady;
    bit                rx_steady;
    bit                long_hold_req;

    pixel_hue_set_grey_bw_recolor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pix_in    (pix_in_ch),
        .pix_out   (pix_out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        else if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Random content, with bias toward grey pixels, saturated channels
    // and values near the black-white threshold.
    function automatic pixel_t random_pixel();
        pixel_t      px;
        int unsigned roll;
        roll = $urandom_range(99);
        px.red   = PIX_W'($urandom_range(255));
        px.green = PIX_W'($urandom_range(255));
        px.blue  = PIX_W'($urandom_range(255));
        if (roll < 10)
        begin
            px.green = px.red;
            px.blue  = px.red;
        end
        else if (roll < 25)
        begin
            px.red   = $urandom_range(1) ? 8'd255 : 8'd0;
            px.green = $urandom_range(1) ? 8'd255 : 8'd0;
            px.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
        end
        else if (roll < 40)
        begin
            px.red   = PIX_W'($urandom_range(131, 125));
            px.green = PIX_W'($urandom_range(131, 125));
            px.blue  = PIX_W'($urandom_range(131, 125));
        end
        return px;
    endfunction

    // Observe both channels at the rising edge; outputs first, since an
    // output accepted now always belongs to an earlier input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_out_ch.valid && pix_out_ch.ready)
                sb.check_output({pix_out_ch.red_out, pix_out_ch.green_out,
                                 pix_out_ch.blue_out});
            if (pix_in_ch.valid && pix_in_ch.ready)
            begin
                sb.note_input({pix_in_ch.red_in, pix_in_ch.green_in, pix_in_ch.blue_in});
                in_count++;
            end
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        int unsigned hold;
        bit          hold_taken;
        hold = 0;
        hold_taken = 1'b0;
        pix_out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold = LONG_HOLD;
            end
            if (!rst_n)
                pix_out_ch.ready = 1'b0;
            else if (hold != 0)
            begin
                pix_out_ch.ready = 1'b0;
                hold--;
            end
            else
            begin
                pix_out_ch.ready = 1'b1;
                if (!rx_steady)
                    hold = pick_gap();
            end
        end
    end

    // Offer one pixel and return at the falling edge after its transaction.
    // Called at a falling edge; valid stays high for a back-to-back item.
    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        int unsigned target;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            pix_in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in_ch.valid    = 1'b1;
        pix_in_ch.red_in   = px.red;
        pix_in_ch.green_in = px.green;
        pix_in_ch.blue_in  = px.blue;
        target = in_count + 1;
        while (in_count != target)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Let the pipeline empty, then rewrite every register. The enables get
    // random upper bits, which the block must ignore.
    task automatic apply_cfg(input bit he, input logic [HUE_W-1:0] hv,
                             input bit ge, input bit be);
        pix_in_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(REG_HUE_EN,  {8'($urandom), he});
        write_reg(REG_HUE_VAL, hv);
        write_reg(REG_GREY_EN, {8'($urandom), ge});
        write_reg(REG_BW_EN,   {8'($urandom), be});
    endtask

    task automatic directed(input bit he, input logic [HUE_W-1:0] hv,
                            input bit ge, input bit be, input pixel_t px);
        apply_cfg(he, hv, ge, be);
        send_pixel(px);
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [HUE_W-1:0] hue_list[11];
        logic [HUE_W-1:0] hv;
        bit               he, ge, be;
        hue_list = '{9'd0, 9'd30, 9'd60, 9'd119, 9'd120, 9'd180, 9'd240,
                     9'd300, 9'd359, 9'd360, 9'd511};
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        pix_in_ch.valid = 1'b0;
        pix_in_ch.red_in = '0;
        pix_in_ch.green_in = '0;
        pix_in_ch.blue_in = '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        long_hold_req = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Pass-through with all stages off, extremes of the channels.
        directed(1'b0, 9'd0, 1'b0, 1'b0, {8'd0, 8'd0, 8'd0});
        directed(1'b0, 9'd0, 1'b0, 1'b0, {8'd255, 8'd255, 8'd255});
        directed(1'b0, 9'd0, 1'b0, 1'b0, {8'd255, 8'd0, 8'd0});
        directed(1'b0, 9'd0, 1'b0, 1'b0, {8'd0, 8'd128, 8'd255});

        // Hue stage in every sector, at sector edges and past a full turn.
        foreach (hue_list[i])
            directed(1'b1, hue_list[i], 1'b0, 1'b0, {8'd200, 8'd100, 8'd50});
        // A grey pixel keeps all channels at its maximum.
        directed(1'b1, 9'd200, 1'b0, 1'b0, {8'd77, 8'd77, 8'd77});

        // Greyscale alone, with truncation of the average.
        directed(1'b0, 9'd0, 1'b1, 1'b0, {8'd255, 8'd255, 8'd254});
        directed(1'b0, 9'd0, 1'b1, 1'b0, {8'd1, 8'd1, 8'd0});

        // Black-white alone, right at the threshold.
        directed(1'b0, 9'd0, 1'b0, 1'b1, {8'd128, 8'd128, 8'd128});
        directed(1'b0, 9'd0, 1'b0, 1'b1, {8'd127, 8'd128, 8'd128});

        // All three stages chained.
        directed(1'b1, 9'd120, 1'b1, 1'b1, {8'd255, 8'd0, 8'd0});
        directed(1'b1, 9'd511, 1'b1, 1'b1, {8'd0, 8'd0, 8'd255});

        // Random phases, each with its own settings and idling pattern.
        for (int unsigned phase = 0; phase < RAND_PHASES; phase++)
        begin
            he = ($urandom_range(99) < 75);
            hv = ($urandom_range(4) == 0) ? HUE_W'($urandom_range(511, 360))
                                          : HUE_W'($urandom_range(359));
            ge = 1'($urandom_range(1));
            be = 1'($urandom_range(1));
            case (phase)
                0: begin he = 1'b1; hv = 9'd0;   ge = 1'b1; be = 1'b1; end
                1: begin he = 1'b1; hv = 9'd359; ge = 1'b0; be = 1'b0; end
                2: begin he = 1'b1; hv = 9'd511; ge = 1'b0; be = 1'b1; end
                3: begin he = 1'b0; hv = 9'd0;   ge = 1'b0; be = 1'b0; end
                default: ;
            endcase
            apply_cfg(he, hv, ge, be);
            tx_steady = ($urandom_range(3) == 0);
            rx_steady = ($urandom_range(3) == 0);
            // Hold the output off for a long stretch while inputs keep coming.
            if (phase == 1)
            begin
                tx_steady = 1'b1;
                rx_steady = 1'b0;
                long_hold_req = 1'b1;
            end
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
                send_pixel(random_pixel());
        end
        pix_in_ch.valid = 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
